// ----- hw/rtl/sce_pkg.sv -----
package sce_pkg;

  // Vector capacity and the widths that follow from it
  localparam int MAX_CLASSES = 64;
  localparam int IDX_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_CLASSES + 1);

  // Fixed-point constants, Q30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Series length of the exponential and quotient bits of the divider
  localparam int TAYLOR_TERMS = 12;
  localparam int DIV_STEPS = 17;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic drop;
    logic exp_start;
    logic store;
    logic ln_start;
    logic rd;
    logic div_start;
    logic fill;
    logic advance;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic exp_done;
    logic ln_done;
    logic div_done;
    logic full;
    logic in_last;
    logic last_idx;
  } sts_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] val;
    case (k)
      4'd1:    val = 33'd4294967296;
      4'd2:    val = 33'd2147483648;
      4'd3:    val = 33'd1431655765;
      4'd4:    val = 33'd1073741824;
      4'd5:    val = 33'd858993459;
      4'd6:    val = 33'd715827882;
      4'd7:    val = 33'd613566756;
      4'd8:    val = 33'd536870912;
      4'd9:    val = 33'd477218588;
      4'd10:   val = 33'd429496729;
      4'd11:   val = 33'd390451572;
      4'd12:   val = 33'd357913941;
      default: val = 33'd4294967296;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/sce_exp.sv -----
module sce_exp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] logit,
  output logic               done,
  output logic [31:0]        result
);

  typedef enum logic [5:0] {
    E_IDLE  = 6'b000001,
    E_FRAC  = 6'b000010,
    E_MUL   = 6'b000100,
    E_RCP   = 6'b001000,
    E_ACC   = 6'b010000,
    E_SCALE = 6'b100000
  } ex_state_t;

  ex_state_t   state;
  logic [47:0] t;
  logic [4:0]  ip_u;
  logic [29:0] g;
  logic [30:0] term;
  logic [31:0] r;
  logic [3:0]  k;
  logic [60:0] tp;
  logic [63:0] pr;

  logic signed [47:0] y_full;
  logic [59:0]        g_prod;
  logic [30:0]        v;
  logic [30:0]        q0;
  logic [34:0]        rem;
  logic [30:0]        q;
  logic [4:0]         amt;
  logic [32:0]        rnd;

  // Scale by log2(e), split into integer part and fraction
  assign y_full = 48'(logit) * 48'(signed'({1'b0, sce_pkg::LOG2E_Q30}));
  assign g_prod = 60'(t[41:12]) * 60'(sce_pkg::LN2_Q30);

  // Divide the series product by k: reciprocal estimate, then one correction
  always_comb begin
    v   = tp[60:30];
    q0  = pr[62:32];
    rem = 35'(v) - 35'(q0) * 35'(k);
    q   = (rem >= 35'(k)) ? q0 + 31'd1 : q0;
    amt = 5'd26 - ip_u;
    rnd = 33'(r) + (33'd1 << (amt - 5'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (start) begin
            t     <= unsigned'(y_full) + (48'd1 << 46);
            state <= E_FRAC;
          end
        end
        E_FRAC: begin
          g     <= g_prod[59:30];
          ip_u  <= t[46:42];
          term  <= 31'd1 << 30;
          r     <= 32'd1 << 30;
          k     <= 4'd1;
          state <= E_MUL;
        end
        E_MUL: begin
          tp    <= 61'(term) * 61'(g);
          state <= E_RCP;
        end
        E_RCP: begin
          pr    <= 64'(v) * 64'(sce_pkg::recip(k));
          state <= E_ACC;
        end
        E_ACC: begin
          term <= q;
          r    <= r + 32'(q);
          k    <= k + 4'd1;
          if (k == 4'(sce_pkg::TAYLOR_TERMS)) begin
            state <= E_SCALE;
          end else begin
            state <= E_MUL;
          end
        end
        E_SCALE: begin
          // Apply 2^n into Q20, rounding right shifts half up
          if (ip_u >= 5'd26) begin
            result <= (ip_u == 5'd27) ? {r[30:0], 1'b0} : r;
          end else begin
            result <= 32'(rnd >> amt);
          end
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sce_ln.sv -----
module sce_ln (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [39:0]        sum,
  input  logic               label_seen,
  input  logic signed [15:0] label_logit,
  output logic               done,
  output logic [17:0]        loss
);

  typedef enum logic [7:0] {
    L_IDLE = 8'b00000001,
    L_SCAN = 8'b00000010,
    L_NORM = 8'b00000100,
    L_SQR  = 8'b00001000,
    L_FOLD = 8'b00010000,
    L_PROD = 8'b00100000,
    L_SUM  = 8'b01000000,
    L_RND  = 8'b10000000
  } ln_state_t;

  ln_state_t          state;
  logic [39:0]        s;
  logic [5:0]         m;
  logic [30:0]        z;
  logic [61:0]        zz;
  logic [4:0]         b;
  logic [29:0]        frac;
  logic [59:0]        fp;
  logic signed [37:0] mp;
  logic signed [39:0] loss30;

  logic [31:0]        zs;
  logic signed [6:0]  me;
  logic signed [39:0] lab;
  logic signed [39:0] rs;
  logic signed [21:0] lq;

  always_comb begin
    zs  = zz[61:30];
    me  = signed'({1'b0, m}) - 7'sd20;
    lab = label_seen ? (40'(label_logit) <<< 18) : 40'sd0;
    rs  = loss30 + 40'sd131072;
    lq  = 22'(rs >>> 18);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            s     <= sum;
            m     <= 6'd39;
            state <= L_SCAN;
          end
        end
        // Walk down to the leading one
        L_SCAN: begin
          if (s[m]) begin
            state <= L_NORM;
          end else begin
            m <= m - 6'd1;
          end
        end
        L_NORM: begin
          if (m >= 6'd30) begin
            z <= 31'(s >> (m - 6'd30));
          end else begin
            z <= 31'(s << (6'd30 - m));
          end
          b     <= 5'd29;
          frac  <= '0;
          state <= L_SQR;
        end
        L_SQR: begin
          zz    <= 62'(z) * 62'(z);
          state <= L_FOLD;
        end
        // One fraction bit of log2 per squaring
        L_FOLD: begin
          if (zs[31]) begin
            z       <= zs[31:1];
            frac[b] <= 1'b1;
          end else begin
            z <= zs[30:0];
          end
          if (b == 5'd0) begin
            state <= L_PROD;
          end else begin
            b     <= b - 5'd1;
            state <= L_SQR;
          end
        end
        L_PROD: begin
          fp    <= 60'(frac) * 60'(sce_pkg::LN2_Q30);
          mp    <= 38'(me) * 38'(signed'({1'b0, sce_pkg::LN2_Q30}));
          state <= L_SUM;
        end
        L_SUM: begin
          loss30 <= 40'(mp) + 40'(signed'({1'b0, fp[59:30]})) - lab;
          state  <= L_RND;
        end
        // Round to Q12 and saturate
        L_RND: begin
          if (lq > 22'sd131071) begin
            loss <= 18'h1FFFF;
          end else if (lq < -22'sd131072) begin
            loss <= 18'h20000;
          end else begin
            loss <= lq[17:0];
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sce_div.sv -----
module sce_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [15:0] quo
);

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } div_state_t;

  div_state_t  state;
  logic [40:0] rem;
  logic [16:0] nlo;
  logic [39:0] den_q;
  logic [16:0] q;
  logic [4:0]  cnt;

  logic [40:0] trial;
  logic        take;
  logic [16:0] q_new;

  // One restoring step per cycle
  always_comb begin
    trial = {rem[39:0], nlo[16]};
    take  = trial >= {1'b0, den_q};
    q_new = {q[15:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            rem   <= 41'(num[47:17]);
            nlo   <= num[16:0];
            den_q <= den;
            q     <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= take ? trial - {1'b0, den_q} : trial;
          nlo <= {nlo[15:0], 1'b0};
          q   <= q_new;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(sce_pkg::DIV_STEPS - 1)) begin
            quo   <= q_new[15:0];
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sce_dp.sv -----
module sce_dp (
  input  logic                clk,
  input  logic                rst,
  input  sce_pkg::cmd_t       cmd,
  output sce_pkg::sts_t       sts,
  input  logic signed [15:0]  logit,
  input  logic [15:0]         target,
  input  logic                last_element,
  output logic [5:0]          class_index,
  output logic [15:0]         probability,
  output logic signed [16:0]  gradient,
  output logic signed [17:0]  loss,
  output logic                label_missing,
  output logic                length_overflow,
  output logic                last_result
);

  logic [31:0] exp_mem [sce_pkg::MAX_CLASSES];
  logic [15:0] tgt_mem [sce_pkg::MAX_CLASSES];

  logic [sce_pkg::CNT_W-1:0] count;
  logic [sce_pkg::IDX_W-1:0] rd_idx;
  logic [39:0]               exp_sum;
  logic signed [15:0]        logit_q;
  logic [15:0]               target_q;
  logic signed [15:0]        label_logit;
  logic                      label_seen;
  logic                      overflow_seen;
  logic [31:0]               exp_rd;
  logic [15:0]               tgt_rd;

  logic        exp_done;
  logic [31:0] exp_res;
  logic        ln_done;
  logic [17:0] ln_loss;
  logic        div_done;
  logic [15:0] quo;
  logic [47:0] div_num;

  sce_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.exp_start),
    .logit  (logit),
    .done   (exp_done),
    .result (exp_res)
  );

  sce_ln u_ln (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.ln_start),
    .sum         (exp_sum),
    .label_seen  (label_seen),
    .label_logit (label_logit),
    .done        (ln_done),
    .loss        (ln_loss)
  );

  // Rounded quotient: (e * 2^15 + sum / 2) / sum
  assign div_num = 48'({exp_rd, 15'b0}) + 48'(exp_sum[39:1]);

  sce_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (exp_sum),
    .done  (div_done),
    .quo   (quo)
  );

  // Status back to the controller
  always_comb begin
    sts.exp_done = exp_done;
    sts.ln_done  = ln_done;
    sts.div_done = div_done;
    sts.full     = count == sce_pkg::CNT_W'(sce_pkg::MAX_CLASSES);
    sts.in_last  = last_element;
    sts.last_idx = (sce_pkg::CNT_W'(rd_idx) + 1'b1) == count;
  end

  // Element stores, registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      exp_mem[count[sce_pkg::IDX_W-1:0]] <= exp_res;
      tgt_mem[count[sce_pkg::IDX_W-1:0]] <= target_q;
    end
    if (cmd.rd) begin
      exp_rd <= exp_mem[rd_idx];
      tgt_rd <= tgt_mem[rd_idx];
    end
  end

  // Capture the incoming element
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      logit_q  <= logit;
      target_q <= target;
    end
  end

  // Run state: sum, count, first label, overflow, read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      rd_idx        <= '0;
      exp_sum       <= '0;
      label_logit   <= '0;
      label_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear) begin
      count         <= '0;
      rd_idx        <= '0;
      exp_sum       <= '0;
      label_logit   <= '0;
      label_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.drop) begin
        overflow_seen <= 1'b1;
      end
      if (cmd.store) begin
        exp_sum <= exp_sum + 40'(exp_res);
        count   <= count + 1'b1;
        if (!label_seen && target_q != 16'd0) begin
          label_seen  <= 1'b1;
          label_logit <= logit_q;
        end
      end
      if (cmd.advance) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      class_index <= 6'(rd_idx);
      probability <= quo;
      gradient    <= signed'({1'b0, quo}) - signed'({1'b0, tgt_rd});
      last_result <= sts.last_idx;
    end
  end

  assign loss            = signed'(ln_loss);
  assign label_missing   = ~label_seen;
  assign length_overflow = overflow_seen;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sce_pkg::CNT_W'(sce_pkg::MAX_CLASSES))
    else $error("element count beyond capacity");

  a_store_step: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> count == $past(count) + 1'b1)
    else $error("store did not advance the count");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> sce_pkg::CNT_W'(rd_idx) < count)
    else $error("read of an entry not written in this run");

  a_clear_run: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> exp_sum == 40'd0 && count == '0 && !overflow_seen)
    else $error("run state not cleared");

endmodule

// ----- hw/rtl/sce_ctrl.sv -----
module sce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sce_pkg::cmd_t cmd,
  input  sce_pkg::sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_EXP   = 8'b00000010,
    S_LNGO  = 8'b00000100,
    S_LN    = 8'b00001000,
    S_RD    = 8'b00010000,
    S_START = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_q;
  logic   accept;

  assign in_stall  = rst | (state != S_IDLE);
  assign out_valid = state == S_OUT;
  assign accept    = in_valid & ~in_stall;

  // Sequence one element, then the normalisation pass
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!sts.full) begin
            cmd.load      = 1'b1;
            cmd.exp_start = 1'b1;
            state_next    = S_EXP;
          end else begin
            cmd.drop = 1'b1;
            if (sts.in_last) begin
              state_next = S_LNGO;
            end
          end
        end
      end
      S_EXP: begin
        if (sts.exp_done) begin
          cmd.store  = 1'b1;
          state_next = last_q ? S_LNGO : S_IDLE;
        end
      end
      S_LNGO: begin
        cmd.ln_start = 1'b1;
        state_next   = S_LN;
      end
      S_LN: begin
        if (sts.ln_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.fill   = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.last_idx) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        last_q <= sts.in_last;
      end
    end
  end

endmodule

// ----- hw/rtl/softmax_cross_entropy_unit.sv -----
// Fixed-point softmax with cross-entropy loss over one logit vector.
// Input channel (in_valid/in_stall): one element per transfer, a Q4.12
// logit with its Q1.15 target; last_element closes the vector. Up to
// MAX_CLASSES elements are kept; further ones are dropped and flagged.
// Each stored element passes through the shared exponential unit (twelve
// series terms, each multiply, reciprocal, accumulate); in_stall is high meanwhile.
// After the last element the loss is formed by a leading-one scan plus
// thirty squaring steps, then one result per stored element goes out on
// the output channel (out_valid/out_stall), each quotient formed by the
// 17-step serial divider. A result waits in its register while out_stall
// is high, and the next one is started only after its transfer.
// last_result marks the end of the run; the run state then clears and a
// new vector may begin. Synchronous reset returns the block to idle with
// an empty vector; the element stores need no clearing.
module softmax_cross_entropy_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] logit,
  input  logic [15:0]        target,
  input  logic               last_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         class_index,
  output logic [15:0]        probability,
  output logic signed [16:0] gradient,
  output logic signed [17:0] loss,
  output logic               label_missing,
  output logic               length_overflow,
  output logic               last_result
);

  sce_pkg::cmd_t cmd;
  sce_pkg::sts_t sts;

  sce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sce_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .logit           (logit),
    .target          (target),
    .last_element    (last_element),
    .class_index     (class_index),
    .probability     (probability),
    .gradient        (gradient),
    .loss            (loss),
    .label_missing   (label_missing),
    .length_overflow (length_overflow),
    .last_result     (last_result)
  );

endmodule
